>>> hw/rtl/h36_pkg.sv
package h36_pkg;

  localparam int unsigned NumLanes          = 5;
  localparam int unsigned DefaultFieldWidth = 5;
  localparam int unsigned ValueWidth        = 27;
  localparam int unsigned TermWidth         = 27;
  localparam int unsigned SumWidth          = 28;

  localparam logic [7:0] ChrNul   = 8'h00;
  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrTab   = 8'h09;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrMinus = 8'h2D;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;
  localparam logic [7:0] ChrUpA   = 8'h41;
  localparam logic [7:0] ChrUpZ   = 8'h5A;
  localparam logic [5:0] LetterBase = 6'd10;

  // Per-character classification found by one lane.
  typedef struct packed {
    logic       term;
    logic       ws;
    logic       space;
    logic       digit;
    logic       letter;
    logic       minus;
    logic [5:0] dval;
  } lane_class_t;

  // Field-level decisions carried from the merge control stage to the sum stage.
  typedef struct packed {
    logic       bad;
    logic       empty;
    logic       neg;
    logic       hyb;
    logic [2:0] width;
  } merge_ctrl_t;

  // Positional weight of a digit: base 10 or base 36.
  function automatic logic [20:0] digit_weight(input logic hyb, input logic [2:0] expo);
    logic [20:0] w;
    w = 21'd0;
    case (expo)
      3'd0: w = 21'd1;
      3'd1: w = hyb ? 21'd36      : 21'd10;
      3'd2: w = hyb ? 21'd1296    : 21'd100;
      3'd3: w = hyb ? 21'd46656   : 21'd1000;
      3'd4: w = hyb ? 21'd1679616 : 21'd10000;
      default: w = 21'd0;
    endcase
    return w;
  endfunction

  // 10^w - 10*36^(w-1): places "A0..0" right after "99..9".
  function automatic logic signed [SumWidth-1:0] hyb_offset(input logic [2:0] width);
    logic signed [SumWidth-1:0] o;
    o = '0;
    case (width)
      3'd2: o = -28'sd260;
      3'd3: o = -28'sd11960;
      3'd4: o = -28'sd456560;
      3'd5: o = -28'sd16696160;
      default: o = '0;
    endcase
    return o;
  endfunction

endpackage

>>> hw/rtl/hybrid36_int_field_decode_core.sv
// Channel   | Handshake        | Payload
// ----------+------------------+---------------------------------------------
// command   | start_i, busy_o  | char_0_i .. char_4_i, chars_present_i
// result    | done_o (strobe)  | value_o, bad_field_o
//
// One transaction per cycle: busy_o never rises, so start_i may be high on
// every clock. Each result passes through the registered stages lane
// classify, merge control with lane digit products, then the sum stage.
// Reset clears only the stage valid flags; payload registers hold junk until
// loaded. The receiver cannot stall; done_o is high for exactly one cycle per
// transaction, in command order.
module hybrid36_int_field_decode_core import h36_pkg::*; #(
  parameter int unsigned FieldWidth = DefaultFieldWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [7:0]                   char_0_i,
  input  logic [7:0]                   char_1_i,
  input  logic [7:0]                   char_2_i,
  input  logic [7:0]                   char_3_i,
  input  logic [7:0]                   char_4_i,
  input  logic [2:0]                   chars_present_i,
  output logic                         done_o,
  output logic signed [ValueWidth-1:0] value_o,
  output logic                         bad_field_o
);

  logic [NumLanes-1:0][7:0]           chars;
  lane_class_t [NumLanes-1:0]         lane_class;
  logic [NumLanes-1:0][TermWidth-1:0] lane_term;
  logic [NumLanes-1:0]                term_en;
  logic [NumLanes-1:0][2:0]           expo;
  logic                               term_load, hyb;
  logic                               accept;
  logic                               v1_q;
  logic [2:0]                         count_d, count_q;

  // Pipeline takes a command every cycle.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign chars[0] = char_0_i;
  assign chars[1] = char_1_i;
  assign chars[2] = char_2_i;
  assign chars[3] = char_3_i;
  assign chars[4] = char_4_i;

  // Clamp the character count to the column width.
  assign count_d = (chars_present_i > 3'(FieldWidth)) ? 3'(FieldWidth) : chars_present_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      count_q <= count_d;
    end
  end

  // One lane per character: classify, then weight its digit.
  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    h36_lane u_lane (
      .clk_i       (clk_i),
      .load_i      (accept),
      .char_i      (chars[g]),
      .class_o     (lane_class[g]),
      .term_load_i (term_load),
      .term_en_i   (term_en[g]),
      .hyb_i       (hyb),
      .expo_i      (expo[g]),
      .term_o      (lane_term[g])
    );
  end

  // Find the field bounds and mode, then sum the lane terms.
  h36_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v1_q),
    .count_i     (count_q),
    .class_i     (lane_class),
    .term_load_o (term_load),
    .term_en_o   (term_en),
    .hyb_o       (hyb),
    .expo_o      (expo),
    .term_i      (lane_term),
    .done_o      (done_o),
    .value_o     (value_o),
    .bad_o       (bad_field_o)
  );

endmodule

>>> hw/rtl/h36_lane.sv
module h36_lane import h36_pkg::*; (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  logic [7:0]           char_i,
  output lane_class_t          class_o,
  input  logic                 term_load_i,
  input  logic                 term_en_i,
  input  logic                 hyb_i,
  input  logic [2:0]           expo_i,
  output logic [TermWidth-1:0] term_o
);

  lane_class_t          class_d, class_q;
  logic [TermWidth-1:0] term_d, term_q;

  always_comb begin
    class_d.term   = (char_i == ChrNul) || (char_i == ChrLf) || (char_i == ChrCr);
    class_d.space  = (char_i == ChrSpace);
    class_d.ws     = (char_i == ChrSpace) || ((char_i >= ChrTab) && (char_i <= ChrCr));
    class_d.digit  = (char_i >= ChrZero) && (char_i <= ChrNine);
    class_d.letter = (char_i >= ChrUpA) && (char_i <= ChrUpZ);
    class_d.minus  = (char_i == ChrMinus);
    if (class_d.letter) begin
      class_d.dval = 6'(char_i - ChrUpA) + LetterBase;
    end else begin
      class_d.dval = 6'(char_i - ChrZero);
    end
  end

  // Digit times its place weight; zero outside the digit span.
  always_comb begin
    if (term_en_i) begin
      term_d = TermWidth'(class_q.dval) * TermWidth'(digit_weight(hyb_i, expo_i));
    end else begin
      term_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      class_q <= class_d;
    end
    if (term_load_i) begin
      term_q <= term_d;
    end
  end

  assign class_o = class_q;
  assign term_o  = term_q;

endmodule

>>> hw/rtl/h36_merge.sv
module h36_merge import h36_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [2:0]                    count_i,
  input  lane_class_t [NumLanes-1:0]    class_i,
  output logic                          term_load_o,
  output logic [NumLanes-1:0]           term_en_o,
  output logic                          hyb_o,
  output logic [NumLanes-1:0][2:0]      expo_o,
  input  logic [NumLanes-1:0][TermWidth-1:0] term_i,
  output logic                          done_o,
  output logic signed [ValueWidth-1:0]  value_o,
  output logic                          bad_o
);

  logic [NumLanes-1:0] live;
  logic [2:0]          fld_end, fld_start, dig_start, width;
  lane_class_t         first;
  logic                empty, hyb, neg, dec_bad, hyb_bad;
  merge_ctrl_t         ctrl_d, ctrl_q;
  logic                v2_q, done_q;
  logic signed [SumWidth-1:0]   acc, res;
  logic signed [ValueWidth-1:0] value_d, value_q;
  logic                         bad_q;

  always_comb begin
    fld_end   = 3'd0;
    fld_start = 3'd0;
    first     = class_i[0];
    dec_bad   = 1'b0;
    hyb_bad   = 1'b0;
    term_en_o = '0;
    expo_o    = '0;
    // Lane is live while inside the count and no line end was seen up to it.
    for (int i = 0; i < NumLanes; i++) begin
      if (i == 0) begin
        live[i] = (count_i > 3'(i)) && !class_i[i].term;
      end else begin
        live[i] = live[i-1] && (count_i > 3'(i)) && !class_i[i].term;
      end
    end
    // Strip trailing whitespace.
    for (int i = 0; i < NumLanes; i++) begin
      if (live[i] && !class_i[i].ws) begin
        fld_end = 3'(i + 1);
      end
    end
    // Skip leading spaces.
    fld_start = fld_end;
    for (int i = NumLanes - 1; i >= 0; i--) begin
      if ((3'(i) < fld_end) && !class_i[i].space) begin
        fld_start = 3'(i);
      end
    end
    for (int i = 0; i < NumLanes; i++) begin
      if (3'(i) == fld_start) begin
        first = class_i[i];
      end
    end
    empty     = (fld_start == fld_end);
    hyb       = !(first.digit || first.minus);
    neg       = !hyb && first.minus;
    dig_start = fld_start + 3'(neg);
    width     = fld_end - fld_start;
    if (!hyb && (dig_start == fld_end)) begin
      dec_bad = 1'b1;
    end
    for (int i = 0; i < NumLanes; i++) begin
      if ((3'(i) >= dig_start) && (3'(i) < fld_end)) begin
        term_en_o[i] = 1'b1;
        expo_o[i]    = fld_end - 3'd1 - 3'(i);
        if (!class_i[i].digit) begin
          dec_bad = 1'b1;
        end
        if (!class_i[i].digit && !class_i[i].letter) begin
          hyb_bad = 1'b1;
        end
      end
    end
    ctrl_d.empty = empty;
    ctrl_d.bad   = !empty && (hyb ? hyb_bad : dec_bad);
    ctrl_d.neg   = neg;
    ctrl_d.hyb   = hyb;
    ctrl_d.width = width;
  end

  assign term_load_o = valid_i;
  assign hyb_o       = hyb;

  // Add the lane terms, apply the hybrid offset and the sign.
  always_comb begin
    acc = '0;
    for (int i = 0; i < NumLanes; i++) begin
      acc = acc + SumWidth'(term_i[i]);
    end
    if (ctrl_q.hyb) begin
      acc = acc + hyb_offset(ctrl_q.width);
    end
    res = ctrl_q.neg ? -acc : acc;
    if (ctrl_q.bad || ctrl_q.empty) begin
      value_d = '0;
    end else begin
      value_d = res[ValueWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v2_q   <= valid_i;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      ctrl_q <= ctrl_d;
    end
    if (v2_q) begin
      value_q <= value_d;
      bad_q   <= ctrl_q.bad;
    end
  end

  assign done_o  = done_q;
  assign value_o = value_q;
  assign bad_o   = bad_q;

endmodule

>>> bench/hybrid36_int_field_decode_core_test.sv
module hybrid36_int_field_decode_core_test import h36_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] ChrVt   = 8'h0B;
  localparam logic [7:0] ChrFf   = 8'h0C;
  localparam logic [7:0] ChrPlus = 8'h2B;
  localparam logic [7:0] ChrLowA = 8'h61;

  localparam bit Typed     = 1'b1;
  localparam bit Predicted = 1'b0;

  localparam int unsigned RandomFields = 1300;
  localparam int unsigned QuietTail    = 150;  // no idling over the last fields
  localparam int unsigned DrainCycles  = 10;   // pipeline is three deep

  // One decoded column, as the block reports it.
  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         bad;
  } field_value_t;

  // One pending transaction: what it must decode to, and its order number.
  typedef struct packed {
    field_value_t result;
    logic [31:0]  seq;
  } pending_field_t;

  // One directed row. The text holds char_0 in its top byte.
  typedef struct packed {
    logic [39:0]                  text;
    logic [2:0]                   count;
    logic                         typed;
    logic signed [ValueWidth-1:0] value;
    logic                         bad;
  } field_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic [7:0]                   char_0_i;
  logic [7:0]                   char_1_i;
  logic [7:0]                   char_2_i;
  logic [7:0]                   char_3_i;
  logic [7:0]                   char_4_i;
  logic [2:0]                   chars_present_i;
  logic                         done_o;
  logic signed [ValueWidth-1:0] value_o;
  logic                         bad_field_o;

  // Typed expectation that travels with the payload of a directed row.
  logic                         row_typed;
  logic signed [ValueWidth-1:0] row_value;
  logic                         row_bad;

  pending_field_t pending_fields_q[$];
  field_row_t     directed_rows_q[$];
  int unsigned    fields_accepted;
  int unsigned    fields_checked;
  int unsigned    mismatch_count;

  hybrid36_int_field_decode_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .char_0_i       (char_0_i),
    .char_1_i       (char_1_i),
    .char_2_i       (char_2_i),
    .char_3_i       (char_3_i),
    .char_4_i       (char_4_i),
    .chars_present_i(chars_present_i),
    .done_o         (done_o),
    .value_o        (value_o),
    .bad_field_o    (bad_field_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run (about 0.3 ms).
  initial begin
    #4_000_000;
    $display("hybrid36_int_field_decode_core_test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Character classes
  // ---------------------------------------------------------------------------

  function automatic bit is_digit(input logic [7:0] c);
    return c >= ChrZero && c <= ChrNine;
  endfunction

  // Trailing strip treats space and TAB..CR as blank.
  function automatic bit is_blank(input logic [7:0] c);
    return c == ChrSpace || (c >= ChrTab && c <= ChrCr);
  endfunction

  // NUL, LF and CR end the line inside the field.
  function automatic bit is_line_end(input logic [7:0] c);
    return c == ChrNul || c == ChrLf || c == ChrCr;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: decode one column from its text and character count
  // ---------------------------------------------------------------------------

  function automatic field_value_t decode_field_value(input logic [39:0] text,
                                                      input logic [2:0]  count);
    logic [7:0]   c [5];
    int unsigned  avail;
    int unsigned  len;
    int unsigned  p;
    int unsigned  digits;
    longint       acc;
    longint       pow10;
    longint       pow36;
    bit           neg;
    bit           junk;
    field_value_t r;
    for (int i = 0; i < 5; i++) c[i] = text[39 - 8*i -: 8];
    r.value = '0;
    r.bad   = 1'b0;
    // Clamp the count, then stop at the first line end.
    avail = (count > DefaultFieldWidth) ? DefaultFieldWidth : count;
    len = 0;
    while (len < avail && !is_line_end(c[len])) len++;
    // Strip trailing blanks, skip leading spaces only.
    while (len > 0 && is_blank(c[len-1])) len--;
    p = 0;
    while (p < len && c[p] == ChrSpace) p++;
    if (p == len) return r;
    if (is_digit(c[p]) || c[p] == ChrMinus) begin
      // Signed decimal: at least one digit, nothing after the digits.
      neg = (c[p] == ChrMinus);
      if (neg) p++;
      acc    = 0;
      digits = 0;
      while (p < len && is_digit(c[p])) begin
        acc = acc * 10 + longint'(int'(c[p]) - int'(ChrZero));
        p++;
        digits++;
      end
      if (digits == 0 || p != len) r.bad = 1'b1;
      else r.value = ValueWidth'(neg ? -acc : acc);
    end else begin
      // Hybrid-36: uppercase letters and digits, shifted past 99..9.
      acc    = 0;
      digits = 0;
      junk   = 1'b0;
      for (; p < len; p++) begin
        if (c[p] >= ChrUpA && c[p] <= ChrUpZ)
          acc = acc * 36 + longint'(int'(c[p]) - int'(ChrUpA) + int'(LetterBase));
        else if (is_digit(c[p]))
          acc = acc * 36 + longint'(int'(c[p]) - int'(ChrZero));
        else
          junk = 1'b1;
        digits++;
      end
      if (junk) begin
        r.bad = 1'b1;
      end else begin
        pow10 = 1;
        pow36 = 1;
        for (int i = 0; i < digits; i++) pow10 *= 10;
        for (int i = 1; i < digits; i++) pow36 *= 36;
        r.value = ValueWidth'(acc - 10 * pow36 + pow10);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: queue each accepted transaction, check each strobed result
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned seq,
                                 input int got, input int want);
    $display("mismatch: %s on result %0d: got %0d, expected %0d", what, seq, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    pending_field_t entry;
    if (rst_ni) begin
      // Queue before checking, so a same-edge result would still find its entry.
      if (start_i && !busy_o) begin
        if (row_typed) begin
          entry.result.value = row_value;
          entry.result.bad   = row_bad;
        end else begin
          entry.result = decode_field_value({char_0_i, char_1_i, char_2_i, char_3_i,
                                             char_4_i}, chars_present_i);
        end
        entry.seq = fields_accepted;
        pending_fields_q.push_back(entry);
        fields_accepted++;
      end
      if (done_o) begin
        if (pending_fields_q.size() == 0) begin
          report_mismatch("result with nothing pending", fields_checked,
                          int'(value_o), 0);
        end else begin
          entry = pending_fields_q.pop_front();
          if (value_o !== entry.result.value)
            report_mismatch("value_o", entry.seq, int'(value_o),
                            int'($signed(entry.result.value)));
          if (bad_field_o !== entry.result.bad)
            report_mismatch("bad_field_o", entry.seq, int'(bad_field_o),
                            int'(entry.result.bad));
        end
        fields_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic field_row_t field_row(input logic [39:0] text, input logic [2:0] count,
                                           input bit typed, input int value, input bit bad);
    field_row_t r;
    r.text  = text;
    r.count = count;
    r.typed = typed;
    r.value = ValueWidth'(value);
    r.bad   = bad;
    return r;
  endfunction

  function automatic logic [7:0] pick_blank();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? ChrSpace : ChrTab + 8'(r);
  endfunction

  function automatic logic [7:0] pick_line_end();
    case ($urandom_range(0, 2))
      0:       return ChrNul;
      1:       return ChrLf;
      default: return ChrCr;
    endcase
  endfunction

  function automatic logic [7:0] pick_noise();
    case ($urandom_range(0, 8))
      0:       return ChrZero + 8'($urandom_range(0, 9));
      1:       return ChrUpA + 8'($urandom_range(0, 25));
      2:       return ChrLowA + 8'($urandom_range(0, 25));
      3:       return ChrSpace;
      4:       return ChrMinus;
      5:       return ChrPlus;
      6:       return pick_blank();
      7:       return pick_line_end();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Build one random column: mostly well-formed decimal or hybrid-36 with
  // random content, some blank, some noise, and a share of corrupted ones.
  task automatic make_field(output logic [39:0] text, output logic [2:0] count);
    logic [7:0]  c [5];
    int unsigned kind;
    int unsigned pos;
    int unsigned lead;
    int unsigned body;
    int unsigned fill;
    for (int i = 0; i < 5; i++) c[i] = 8'($urandom_range(0, 255));
    kind = $urandom_range(0, 99);
    lead = $urandom_range(0, 2);
    body = $urandom_range(1, 5);
    pos  = 0;
    if (kind < 75) begin
      while (pos < lead) begin
        c[pos] = ChrSpace;
        pos++;
      end
      if (kind < 40) begin
        if ($urandom_range(0, 2) == 0) begin
          c[pos] = ChrMinus;
          pos++;
        end
        for (int i = 0; i < body && pos < 5; i++) begin
          c[pos] = ChrZero + 8'($urandom_range(0, 9));
          pos++;
        end
      end else begin
        c[pos] = ChrUpA + 8'($urandom_range(0, 25));
        pos++;
        for (int i = 1; i < body && pos < 5; i++) begin
          c[pos] = ($urandom_range(0, 1) == 0) ? ChrUpA + 8'($urandom_range(0, 25))
                                              : ChrZero + 8'($urandom_range(0, 9));
          pos++;
        end
      end
    end else if (kind < 83) begin
      pos = $urandom_range(0, 5);
      for (int i = 0; i < pos; i++) c[i] = pick_blank();
    end else begin
      pos = $urandom_range(1, 5);
      for (int i = 0; i < pos; i++) c[i] = pick_noise();
    end
    // Decide how the field ends: exact count, blank padding, a line end, or any count.
    fill = $urandom_range(0, 9);
    if (fill < 5) begin
      count = 3'(pos);
    end else if (fill < 8) begin
      for (int i = pos; i < 5; i++) c[i] = pick_blank();
      count = 3'($urandom_range(pos, 7));
    end else if (fill < 9) begin
      if (pos < 5) c[pos] = pick_line_end();
      count = 3'($urandom_range(pos, 7));
    end else begin
      count = 3'($urandom_range(0, 7));
    end
    // Break a well-formed field now and then.
    if ($urandom_range(0, 5) == 0) c[$urandom_range(0, 4)] = pick_noise();
    text = {c[0], c[1], c[2], c[3], c[4]};
  endtask

  // Present one transaction and hold it until the block takes it.
  task automatic send_field(input logic [39:0] text, input logic [2:0] count,
                            input bit typed, input logic signed [ValueWidth-1:0] value,
                            input bit bad);
    start_i         <= 1'b1;
    char_0_i        <= text[39:32];
    char_1_i        <= text[31:24];
    char_2_i        <= text[23:16];
    char_3_i        <= text[15:8];
    char_4_i        <= text[7:0];
    chars_present_i <= count;
    row_typed       <= typed;
    row_value       <= value;
    row_bad         <= bad;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start for a burst; scramble the payload so a stale read shows up.
  task automatic idle_sender(input int unsigned cycles);
    start_i         <= 1'b0;
    char_0_i        <= 8'($urandom_range(0, 255));
    char_1_i        <= 8'($urandom_range(0, 255));
    char_2_i        <= 8'($urandom_range(0, 255));
    char_3_i        <= 8'($urandom_range(0, 255));
    char_4_i        <= 8'($urandom_range(0, 255));
    chars_present_i <= 3'($urandom_range(0, 7));
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold off until every pending transaction has returned. Step one edge
  // first so the last accepted transaction is already queued.
  task automatic wait_all_returned();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_fields_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [39:0] text;
    logic [2:0]  count;
    bit          bursty;
    // Drive every input to a known value before the first edge.
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    char_0_i        = 8'h00;
    char_1_i        = 8'h00;
    char_2_i        = 8'h00;
    char_3_i        = 8'h00;
    char_4_i        = 8'h00;
    chars_present_i = 3'd0;
    row_typed       = 1'b0;
    row_value       = '0;
    row_bad         = 1'b0;
    fields_accepted = 0;
    fields_checked  = 0;
    mismatch_count  = 0;

    // Directed rows: typed where the answer is plain, predicted otherwise.
    directed_rows_q.push_back(field_row("     ", 3'd0, Typed, 0, 1'b0));        // empty
    directed_rows_q.push_back(field_row("12345", 3'd0, Typed, 0, 1'b0));        // nothing present
    directed_rows_q.push_back(field_row("99999", 3'd5, Typed, 99999, 1'b0));
    directed_rows_q.push_back(field_row("-9999", 3'd5, Typed, -9999, 1'b0));
    directed_rows_q.push_back(field_row("    0", 3'd5, Typed, 0, 1'b0));
    directed_rows_q.push_back(field_row("A0000", 3'd5, Typed, 100000, 1'b0));   // follows 99999
    directed_rows_q.push_back(field_row("ZZZZZ", 3'd5, Typed, 43770015, 1'b0)); // top of range
    directed_rows_q.push_back(field_row("     ", 3'd5, Typed, 0, 1'b0));        // blank
    directed_rows_q.push_back(field_row({" ", ChrTab, ChrVt, ChrFf, " "}, 3'd5, Typed, 0, 1'b0));
    directed_rows_q.push_back(field_row("   - ", 3'd5, Typed, 0, 1'b1));        // lone minus
    directed_rows_q.push_back(field_row("12 34", 3'd5, Typed, 0, 1'b1));        // junk after digits
    directed_rows_q.push_back(field_row("12x  ", 3'd5, Typed, 0, 1'b1));
    directed_rows_q.push_back(field_row("Abcde", 3'd5, Typed, 0, 1'b1));        // lowercase
    directed_rows_q.push_back(field_row("A+000", 3'd5, Typed, 0, 1'b1));
    directed_rows_q.push_back(field_row("A 000", 3'd5, Typed, 0, 1'b1));        // inner space
    directed_rows_q.push_back(field_row({ChrTab, "123 "}, 3'd5, Typed, 0, 1'b1)); // tab not skipped
    directed_rows_q.push_back(field_row({8'hFF, 8'h80, 8'h7F, 8'h01, 8'hAA}, 3'd5, Typed, 0, 1'b1));
    directed_rows_q.push_back(field_row("12345", 3'd7, Typed, 12345, 1'b0));    // count clamps
    directed_rows_q.push_back(field_row({"123", ChrNul, "9"}, 3'd5, Predicted, 0, 1'b0));
    directed_rows_q.push_back(field_row({"12", ChrLf, "45"}, 3'd6, Predicted, 0, 1'b0));
    directed_rows_q.push_back(field_row({"-7", ChrCr, "xx"}, 3'd5, Predicted, 0, 1'b0));
    directed_rows_q.push_back(field_row({"  42", ChrTab}, 3'd5, Predicted, 0, 1'b0));
    directed_rows_q.push_back(field_row("  A1 ", 3'd5, Predicted, 0, 1'b0));
    directed_rows_q.push_back(field_row("ZZZZZ", 3'd3, Predicted, 0, 1'b0));
    directed_rows_q.push_back(field_row("-0123", 3'd5, Predicted, 0, 1'b0));

    // Hold reset, then release it once.
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table back to back.
    foreach (directed_rows_q[i])
      send_field(directed_rows_q[i].text, directed_rows_q[i].count, directed_rows_q[i].typed,
                 directed_rows_q[i].value, directed_rows_q[i].bad);
    wait_all_returned();

    // Random fields: idle bursts come and go in stretches, none in the tail.
    bursty = 1'b1;
    for (int unsigned n = 0; n < RandomFields; n++) begin
      if (n % 64 == 0) bursty = ($urandom_range(0, 2) != 0);
      if (n == RandomFields / 2) wait_all_returned();
      if (bursty && n < RandomFields - QuietTail && $urandom_range(0, 3) == 0)
        idle_sender($urandom_range(1, 15));
      make_field(text, count);
      send_field(text, count, Predicted, '0, 1'b0);
    end

    // Drain, then keep watching for stray strobes.
    wait_all_returned();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_fields_q.size() == 0) begin
      $display("hybrid36_int_field_decode_core_test passed");
    end else begin
      $display("hybrid36_int_field_decode_core_test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/h36_pkg.sv
hw/rtl/h36_lane.sv
hw/rtl/h36_merge.sv
hw/rtl/hybrid36_int_field_decode_core.sv
bench/hybrid36_int_field_decode_core_test.sv
